// File: rtl/per_source_sequence_gap_tracker_unit_macros.svh
// Assertion macros for the per-source sequence gap tracker.
// Included by the top level; no other dependencies.
`ifndef PER_SOURCE_SEQUENCE_GAP_TRACKER_UNIT_MACROS_SVH
`define PER_SOURCE_SEQUENCE_GAP_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PSGT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PSGT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/psgt_pkg.sv
// Shared types and constants of the per-source sequence gap tracker.
// No dependencies; imported by every module of the block.
package psgt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int DEV_W    = 32;
  localparam int SEQ_W    = 64;
  localparam int CONN_W   = 16;
  localparam int CREDIT_W = 9;
  localparam int HB_W     = 8;
  localparam int OP_W     = 2;
  localparam int KIND_W   = 2;

  localparam logic [HB_W-1:0] HB_RESET = 8'd10;

  // Word layouts on the stream ports
  localparam int IN_BITS    = DEV_W + SEQ_W + 1 + CONN_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = DEV_W + SEQ_W + CONN_W + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_MSG    = 2'd0,
    OP_TICK   = 2'd1,
    OP_REPORT = 2'd2
  } opcode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_GAP    = 2'd0,
    KIND_STALE  = 2'd1,
    KIND_REPORT = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_INSERT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [DEV_W-1:0]    device;
    logic [SEQ_W-1:0]    last_seq;
    logic [CREDIT_W-1:0] credit;   // two's complement, -1..255
    logic                has_conn;
    logic [CONN_W-1:0]   conn;
  } entry_t;

  typedef struct packed {
    kind_e             kind;
    logic [DEV_W-1:0]  device;
    logic [SEQ_W-1:0]  value;
    logic [CONN_W-1:0] conn;
    logic              full;
    logic              last;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic load;
    res_t res;
  } out_ctl_t;

endpackage

// File: rtl/psgt_mem.sv
// Device table memory: one write port, one read port, registered read data.
// Depends on psgt_pkg.
module psgt_mem (
  input  logic               clk_i,
  input  psgt_pkg::mem_req_t req_i,
  output psgt_pkg::entry_t   rdata_o
);
  import psgt_pkg::*;

  entry_t mem_q [TABLE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/psgt_out.sv
// Output register of the gap tracker: holds one result word for the sink.
// Depends on psgt_pkg.
module psgt_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  psgt_pkg::out_ctl_t ctl_i,
  input  logic               ready_i,
  output logic               free_o,
  output logic               valid_o,
  output psgt_pkg::res_t     res_o
);
  import psgt_pkg::*;

  logic valid_q;
  res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.load) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      res_q <= ctl_i.res;
    end
  end

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: rtl/psgt_ctrl.sv
// Sequencer of the gap tracker: sweeps the device table, read-modify-write,
// keeps the valid bits and a one-deep pending result. Depends on psgt_pkg.
module psgt_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_valid_i,
  output logic                         s_ready_o,
  input  logic [psgt_pkg::OP_W-1:0]    opcode_i,
  input  logic [psgt_pkg::DEV_W-1:0]   device_i,
  input  logic [psgt_pkg::SEQ_W-1:0]   seq_i,
  input  logic                         has_conn_i,
  input  logic [psgt_pkg::CONN_W-1:0]  conn_i,
  input  logic                         cfg_we_i,
  input  logic [psgt_pkg::HB_W-1:0]    cfg_wdata_i,
  output psgt_pkg::mem_req_t           mem_req_o,
  input  psgt_pkg::entry_t             mem_rdata_i,
  input  logic                         out_free_i,
  output psgt_pkg::out_ctl_t           out_ctl_o
);
  import psgt_pkg::*;

  state_e                 state_q, state_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [CNT_W-1:0]       n_q, n_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  res_t                   pend_q, pend_d;
  logic                   pend_vld_q, pend_vld_d;
  logic [HB_W-1:0]        hb_q;

  logic [OP_W-1:0]        op_q;
  logic [DEV_W-1:0]       dev_q;
  logic [SEQ_W-1:0]       seq_q;
  logic                   hc_q;
  logic [CONN_W-1:0]      conn_q;

  logic                   in_acc;
  logic                   ent_v;
  logic                   dev_hit;
  logic                   stale;
  logic                   room;
  logic                   found;
  logic                   stall;
  logic                   idx_end;
  logic [SEQ_W-1:0]       diff;
  logic [SEQ_W-1:0]       gap;
  logic [CREDIT_W-1:0]    credit_dec;
  logic [IDX_W-1:0]       free_idx;
  logic                   free_any;
  res_t                   new_res;
  res_t                   none_res;

  assign in_acc    = s_valid_i && (state_q == ST_IDLE);
  assign s_ready_o = (state_q == ST_IDLE);

  assign ent_v   = valid_q[idx_q];
  assign dev_hit = ent_v && (mem_rdata_i.device == dev_q);
  assign stale   = mem_rdata_i.credit[CREDIT_W-1] || (mem_rdata_i.credit == '0);
  assign room    = n_q < CNT_W'(MAX_RESULTS);
  assign idx_end = (idx_q == IDX_W'(TABLE_DEPTH - 1));

  // Gap against last+1, negative differences clamp to zero
  assign diff = seq_q - mem_rdata_i.last_seq - SEQ_W'(1);
  assign gap  = diff[SEQ_W-1] ? '0 : diff;

  // Credit saturates at -1
  assign credit_dec = (mem_rdata_i.credit == '1) ? mem_rdata_i.credit
                                                  : mem_rdata_i.credit - CREDIT_W'(1);

  always_comb begin
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end
  assign free_any = ~&valid_q;

  always_comb begin
    found   = 1'b0;
    new_res = '0;
    unique case (op_q)
      OP_MSG: begin
        found          = dev_hit;
        new_res.kind   = KIND_GAP;
        new_res.device = dev_q;
        new_res.value  = gap;
      end
      OP_TICK: begin
        found          = ent_v && stale && mem_rdata_i.has_conn && room;
        new_res.kind   = KIND_STALE;
        new_res.device = mem_rdata_i.device;
        new_res.conn   = mem_rdata_i.conn;
      end
      OP_REPORT: begin
        found          = ent_v && room;
        new_res.kind   = KIND_REPORT;
        new_res.device = mem_rdata_i.device;
        new_res.value  = mem_rdata_i.last_seq;
      end
      default: begin
        found = 1'b0;
      end
    endcase
  end

  // Hold the sweep when a second result finds the output side still busy
  assign stall = found && pend_vld_q && !out_free_i;

  always_comb begin
    none_res      = '0;
    none_res.kind = KIND_NONE;
    none_res.last = 1'b1;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          idx_d = '0;
          unique case (opcode_i)
            OP_MSG:    state_d = (device_i == '0) ? ST_DONE : ST_READ;
            OP_TICK:   state_d = ST_READ;
            OP_REPORT: state_d = ST_READ;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (stall) begin
          state_d = ST_CHECK;
        end else if ((op_q == OP_MSG) && dev_hit) begin
          state_d = ST_DONE;
        end else if (idx_end) begin
          state_d = (op_q == OP_MSG) ? ST_INSERT : ST_DONE;
        end else begin
          state_d = ST_READ;
          idx_d   = idx_q + IDX_W'(1);
        end
      end
      ST_INSERT: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs: memory accesses, valid bits, pending result, output loads
  always_comb begin
    mem_req_o       = '0;
    mem_req_o.waddr = idx_q;
    mem_req_o.raddr = idx_q;
    mem_req_o.wdata = mem_rdata_i;
    valid_d         = valid_q;
    pend_d          = pend_q;
    pend_vld_d      = pend_vld_q;
    n_d             = n_q;
    out_ctl_o.load  = 1'b0;
    out_ctl_o.res   = pend_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          n_d = '0;
          if ((opcode_i == OP_MSG) && (device_i == '0)) begin
            pend_d      = '0;
            pend_d.kind = KIND_GAP;
            pend_vld_d  = 1'b1;
          end
        end
      end
      ST_READ: begin
        mem_req_o.re = 1'b1;
      end
      ST_CHECK: begin
        if (!stall) begin
          if (found) begin
            pend_d     = new_res;
            pend_vld_d = 1'b1;
            n_d        = n_q + CNT_W'(1);
            out_ctl_o.load = pend_vld_q;
          end
          if ((op_q == OP_MSG) && dev_hit) begin
            mem_req_o.we             = 1'b1;
            mem_req_o.wdata.last_seq = seq_q;
            mem_req_o.wdata.credit   = {1'b0, hb_q};
            if (hc_q) begin
              mem_req_o.wdata.has_conn = 1'b1;
              mem_req_o.wdata.conn     = conn_q;
            end
          end
          if ((op_q == OP_TICK) && ent_v) begin
            mem_req_o.we           = 1'b1;
            mem_req_o.wdata.credit = credit_dec;
            if (found) begin
              valid_d[idx_q] = 1'b0;
            end
          end
        end
      end
      ST_INSERT: begin
        pend_d        = '0;
        pend_d.kind   = KIND_GAP;
        pend_d.device = dev_q;
        pend_d.full   = !free_any;
        pend_vld_d    = 1'b1;
        if (free_any) begin
          mem_req_o.we             = 1'b1;
          mem_req_o.waddr          = free_idx;
          mem_req_o.wdata.device   = dev_q;
          mem_req_o.wdata.last_seq = seq_q;
          mem_req_o.wdata.credit   = {1'b0, hb_q};
          mem_req_o.wdata.has_conn = hc_q;
          mem_req_o.wdata.conn     = hc_q ? conn_q : '0;
          valid_d[free_idx]        = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          out_ctl_o.load = 1'b1;
          if (pend_vld_q) begin
            out_ctl_o.res      = pend_q;
            out_ctl_o.res.last = 1'b1;
          end else begin
            out_ctl_o.res = none_res;
          end
          pend_vld_d = 1'b0;
        end
      end
      default: begin
        pend_vld_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      n_q        <= '0;
      valid_q    <= '0;
      pend_vld_q <= 1'b0;
      hb_q       <= HB_RESET;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      n_q        <= n_d;
      valid_q    <= valid_d;
      pend_vld_q <= pend_vld_d;
      if (cfg_we_i) begin
        hb_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (in_acc) begin
      op_q   <= opcode_i;
      dev_q  <= device_i;
      seq_q  <= seq_i;
      hc_q   <= has_conn_i;
      conn_q <= conn_i;
    end
  end

endmodule

// File: rtl/per_source_sequence_gap_tracker_unit.sv
// Per-source sequence gap tracker. A message reads and checks the table entries in turn up
// to its match, or else to the end of the table and an insert; ticks and reports sweep all
// entries, and a sweep holds while the sink stalls. One word at a time; the registered read
// data of the table memory sets the per-entry pace.
// Reset clears the valid bits and restores heartbeat_credit to 10; no clearing pass.
// Depends on psgt_pkg, psgt_mem, psgt_out, psgt_ctrl and the assertion macro header.
`include "per_source_sequence_gap_tracker_unit_macros.svh"
module per_source_sequence_gap_tracker_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: device_id[31:0], seq_num[95:32], has_connection[96],
  //        connection_handle[112:97], zero pad[119:113]
  input  logic [psgt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: opcode[1:0]
  input  logic [psgt_pkg::OP_W-1:0]         s_axis_tuser,
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: device_out[31:0], value_out[95:32], connection_out[111:96],
  //        table_full[112], zero pad[119:113]
  output logic [psgt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // tuser: result_kind[1:0]
  output logic [psgt_pkg::KIND_W-1:0]       m_axis_tuser,
  output logic                              m_axis_tlast,
  // heartbeat_credit register
  input  logic                              cfg_we_i,
  input  logic [psgt_pkg::HB_W-1:0]         cfg_wdata_i
);
  import psgt_pkg::*;

  // Bit offsets within the input word
  localparam int InSeqLo  = DEV_W;
  localparam int InHcBit  = DEV_W + SEQ_W;
  localparam int InConnLo = InHcBit + 1;
  // Bit offsets within the result word
  localparam int OutConnLo = DEV_W + SEQ_W;
  localparam int OutFull   = OutConnLo + CONN_W;

  mem_req_t mem_req;
  entry_t   mem_rdata;
  out_ctl_t out_ctl;
  logic     out_free;
  res_t     out_res;

  // Sequencer: one entry read in the read state, write-back in the check state.
  // Each sweep visits an entry once and the insert write follows the sweep,
  // so a read never meets a write to the same entry in one cycle.
  psgt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .opcode_i    (s_axis_tuser),
    .device_i    (s_axis_tdata[DEV_W-1:0]),
    .seq_i       (s_axis_tdata[InSeqLo +: SEQ_W]),
    .has_conn_i  (s_axis_tdata[InHcBit]),
    .conn_i      (s_axis_tdata[InConnLo +: CONN_W]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .out_free_i  (out_free),
    .out_ctl_o   (out_ctl)
  );

  // Device table: device, last sequence number, credit, handle
  psgt_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Output register parts the sweep from the sink
  psgt_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (out_ctl),
    .ready_i (m_axis_tready),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .res_o   (out_res)
  );

  // Pack the result word
  always_comb begin
    m_axis_tdata                          = '0;
    m_axis_tdata[DEV_W-1:0]               = out_res.device;
    m_axis_tdata[InSeqLo +: SEQ_W]        = out_res.value;
    m_axis_tdata[OutConnLo +: CONN_W]     = out_res.conn;
    m_axis_tdata[OutFull]                 = out_res.full;
  end
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

  `PSGT_ASSERT_IMPLY(a_load_needs_room, clk_i, rst_ni, out_ctl.load, out_free, "result loaded over a held word")
  `PSGT_ASSERT_IMPLY(a_no_rw_collision, clk_i, rst_ni, mem_req.we && mem_req.re, mem_req.waddr != mem_req.raddr, "table read and write hit one entry")
  `PSGT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second word taken while busy")
  `PSGT_ASSERT_NEXT(a_idle_after_last, clk_i, rst_ni, out_ctl.load && out_ctl.res.last, s_axis_tready, "not idle after final result")

endmodule

// File: tb/sv/tb_per_source_sequence_gap_tracker_unit.sv
// Self-checking bench for the per-source sequence gap tracker: drives message, tick and
// report words, mirrors the device table in a local model and checks every result word.
// Depends on psgt_pkg and per_source_sequence_gap_tracker_unit.
`timescale 1ns / 1ps
module tb_per_source_sequence_gap_tracker_unit;
  import psgt_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400_000;
  localparam int          POOL_SIZE    = 24;
  localparam int          END_PAUSE    = 40;
  // Opcode 3 has no meaning for the block; name it so it is never a bare literal.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DEV_W-1:0]  dev;
    logic [SEQ_W-1:0]  seq;
    logic              has_conn;
    logic [CONN_W-1:0] conn;
  } source_word_t;

  typedef struct {
    kind_e             kind;
    logic [DEV_W-1:0]  dev;
    logic [SEQ_W-1:0]  value;
    logic [CONN_W-1:0] conn;
    logic              full;
    logic              last;
  } tracker_out_t;

  logic                    clk_i;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_DATA_W-1:0]    s_axis_tdata  = '0;
  logic [OP_W-1:0]         s_axis_tuser  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;
  logic [KIND_W-1:0]       m_axis_tuser;
  logic                    m_axis_tlast;
  logic                    cfg_we_i      = 1'b0;
  logic [HB_W-1:0]         cfg_wdata_i   = '0;

  per_source_sequence_gap_tracker_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Local copy of the device table and the credit register
  logic                       tbl_valid   [TABLE_DEPTH];
  logic [DEV_W-1:0]           tbl_dev     [TABLE_DEPTH];
  logic [SEQ_W-1:0]           tbl_seq     [TABLE_DEPTH];
  logic signed [CREDIT_W-1:0] tbl_credit  [TABLE_DEPTH];
  logic                       tbl_hasconn [TABLE_DEPTH];
  logic [CONN_W-1:0]          tbl_conn    [TABLE_DEPTH];
  logic [HB_W-1:0]            hb_credit = HB_RESET;

  source_word_t source_words_q [$];
  tracker_out_t tracker_out_q  [$];

  int unsigned fail_count  = 0;
  int unsigned words_in    = 0;
  int unsigned results_in  = 0;
  int unsigned stale_seen  = 0;
  int unsigned full_seen   = 0;
  int unsigned report_seen = 0;
  int unsigned settings_run = 0;
  int unsigned cycles      = 0;
  logic        steady_flow = 1'b0;   // no idling on either side while set

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
  end

  // Apply one accepted word to the table copy and queue the results it causes.
  task automatic tracker_step(input source_word_t w);
    tracker_out_t r [MAX_RESULTS];
    int           n;
    int           slot;
    logic         hit;
    logic         stale;
    logic [SEQ_W-1:0] gap;
    n    = 0;
    slot = -1;
    hit  = 1'b0;
    for (int i = 0; i < MAX_RESULTS; i++) r[i] = '{KIND_NONE, '0, '0, '0, 1'b0, 1'b0};
    if (w.op == OP_MSG) begin
      if (w.dev == '0) begin
        // untracked device: plain zero gap, table untouched
        r[0] = '{KIND_GAP, '0, '0, '0, 1'b0, 1'b0};
        n    = 1;
      end else begin
        for (int i = 0; i < TABLE_DEPTH && !hit; i++) begin
          if (tbl_valid[i] && tbl_dev[i] == w.dev) begin
            hit = 1'b1;
            gap = w.seq - tbl_seq[i] - 64'd1;
            if (gap[SEQ_W-1]) gap = '0;   // repeat or step back
            tbl_seq[i]    = w.seq;
            tbl_credit[i] = $signed({1'b0, hb_credit});
            if (w.has_conn) begin
              tbl_hasconn[i] = 1'b1;
              tbl_conn[i]    = w.conn;
            end
            r[0] = '{KIND_GAP, w.dev, gap, '0, 1'b0, 1'b0};
          end else if (!tbl_valid[i] && slot < 0) begin
            slot = i;
          end
        end
        if (!hit && slot < 0) begin
          r[0] = '{KIND_GAP, w.dev, '0, '0, 1'b1, 1'b0};
        end else if (!hit) begin
          tbl_valid[slot]   = 1'b1;
          tbl_dev[slot]     = w.dev;
          tbl_seq[slot]     = w.seq;
          tbl_credit[slot]  = $signed({1'b0, hb_credit});
          tbl_hasconn[slot] = w.has_conn;
          tbl_conn[slot]    = w.has_conn ? w.conn : '0;
          r[0] = '{KIND_GAP, w.dev, '0, '0, 1'b0, 1'b0};
        end
        n = 1;
      end
    end else if (w.op == OP_TICK) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (tbl_valid[i]) begin
          stale = (tbl_credit[i] <= 0);
          if (tbl_credit[i] > -1) tbl_credit[i] = tbl_credit[i] - 1;
          if (stale && tbl_hasconn[i] && n < MAX_RESULTS) begin
            r[n] = '{KIND_STALE, tbl_dev[i], '0, tbl_conn[i], 1'b0, 1'b0};
            n++;
            tbl_valid[i] = 1'b0;
          end
        end
      end
    end else if (w.op == OP_REPORT) begin
      for (int i = 0; i < TABLE_DEPTH && n < MAX_RESULTS; i++) begin
        if (tbl_valid[i]) begin
          r[n] = '{KIND_REPORT, tbl_dev[i], tbl_seq[i], '0, 1'b0, 1'b0};
          n++;
        end
      end
    end
    // empty sweep or unused opcode: a single filler word
    if (n == 0) n = 1;
    r[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) tracker_out_q.push_back(r[i]);
  endtask

  function automatic int unsigned draw_wait();
    return steady_flow ? 0 : $urandom_range(0, 13);
  endfunction

  // Source side: present queued words, hold each until taken, then idle a drawn while.
  int unsigned src_wait = 0;
  source_word_t src_word;

  always @(posedge clk_i) begin
    int unsigned g;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_wait      <= 0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      tracker_step(src_word);
      words_in++;
      g = draw_wait();
      if (g == 0 && source_words_q.size() != 0) begin
        // keep tvalid high and move straight on to the next word
        src_word     = source_words_q.pop_front();
        s_axis_tdata <= {{(IN_DATA_W-IN_BITS){1'b0}}, src_word.conn, src_word.has_conn,
                         src_word.seq, src_word.dev};
        s_axis_tuser <= src_word.op;
      end else begin
        s_axis_tvalid <= 1'b0;
        src_wait      <= (g == 0) ? 0 : g - 1;
      end
    end else if (!s_axis_tvalid) begin
      if (src_wait != 0) begin
        src_wait <= src_wait - 1;
      end else if (source_words_q.size() != 0) begin
        src_word      = source_words_q.pop_front();
        s_axis_tdata  <= {{(IN_DATA_W-IN_BITS){1'b0}}, src_word.conn, src_word.has_conn,
                          src_word.seq, src_word.dev};
        s_axis_tuser  <= src_word.op;
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count++;
    end
  endfunction

  // Sink side: compare each taken word with the oldest queued result, then stall a while.
  int unsigned sink_wait = 0;

  always @(posedge clk_i) begin
    int unsigned  g;
    tracker_out_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_wait     <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      results_in++;
      if (m_axis_tuser == KIND_STALE)  stale_seen++;
      if (m_axis_tuser == KIND_REPORT) report_seen++;
      if (m_axis_tdata[DEV_W+SEQ_W+CONN_W]) full_seen++;
      if (tracker_out_q.size() == 0) begin
        $error("result word with nothing outstanding: kind %0d device 0x%0h",
               m_axis_tuser, m_axis_tdata[DEV_W-1:0]);
        fail_count++;
      end else begin
        want = tracker_out_q.pop_front();
        check_field("result_kind", 64'(want.kind), 64'(m_axis_tuser));
        check_field("device_out", 64'(want.dev), 64'(m_axis_tdata[DEV_W-1:0]));
        check_field("value_out", want.value, m_axis_tdata[DEV_W+SEQ_W-1:DEV_W]);
        check_field("connection_out", 64'(want.conn),
                    64'(m_axis_tdata[DEV_W+SEQ_W+CONN_W-1:DEV_W+SEQ_W]));
        check_field("table_full", 64'(want.full), 64'(m_axis_tdata[DEV_W+SEQ_W+CONN_W]));
        check_field("last", 64'(want.last), 64'(m_axis_tlast));
      end
      g = draw_wait();
      if (g != 0) begin
        m_axis_tready <= 1'b0;
        sink_wait     <= g - 1;
      end
    end else if (!m_axis_tready) begin
      if (sink_wait != 0) sink_wait <= sink_wait - 1;
      else                m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               tracker_out_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus
  logic [DEV_W-1:0] pool_dev [POOL_SIZE];
  logic [SEQ_W-1:0] pool_seq [POOL_SIZE];

  task automatic queue_word(input logic [OP_W-1:0] op, input logic [DEV_W-1:0] dev,
                            input logic [SEQ_W-1:0] seq, input logic hc,
                            input logic [CONN_W-1:0] conn);
    source_word_t w;
    w = '{op, dev, seq, hc, conn};
    source_words_q.push_back(w);
  endtask

  // Sample on the falling edge so that words and flags set at the rising edge are seen.
  task automatic wait_drained();
    while (source_words_q.size() != 0 || s_axis_tvalid || tracker_out_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_credit(input logic [HB_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    hb_credit   = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_run++;
  endtask

  // Mostly messages from a pool larger than the table, with near-consecutive sequence
  // numbers; the rest ticks, reports, unknown devices and the unused opcode.
  task automatic queue_random(input int count);
    int               r;
    int               p;
    int               s;
    logic [SEQ_W-1:0] seq;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        p = $urandom_range(0, POOL_SIZE - 1);
        s = $urandom_range(0, 9);
        if (s < 6)      seq = pool_seq[p] + 64'd1 + 64'($urandom_range(0, 3));
        else if (s < 8) seq = pool_seq[p] - 64'($urandom_range(0, 2));
        else            seq = {$urandom, $urandom};
        pool_seq[p] = seq;
        queue_word(OP_MSG, pool_dev[p], seq, $urandom_range(0, 2) != 0,
                   CONN_W'($urandom));
      end else if (r < 62) begin
        queue_word(OP_MSG, ($urandom_range(0, 1) != 0) ? '0 : $urandom,
                   {$urandom, $urandom}, 1'($urandom), CONN_W'($urandom));
      end else if (r < 85) begin
        queue_word(OP_TICK, $urandom, {$urandom, $urandom}, 1'($urandom),
                   CONN_W'($urandom));
      end else if (r < 95) begin
        queue_word(OP_REPORT, $urandom, {$urandom, $urandom}, 1'($urandom),
                   CONN_W'($urandom));
      end else begin
        queue_word(OP_UNUSED, $urandom, {$urandom, $urandom}, 1'($urandom),
                   CONN_W'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    logic [HB_W-1:0] credit_plan [5];
    pool_dev[0] = '1;
    for (int i = 1; i < POOL_SIZE; i++) begin
      pool_dev[i] = $urandom;
      if (pool_dev[i] == '0) pool_dev[i] = 32'd1;
    end
    for (int i = 0; i < POOL_SIZE; i++) pool_seq[i] = {$urandom, $urandom};
    credit_plan = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd1};
    credit_plan[4] = HB_W'($urandom_range(1, 255));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset credit: empty sweeps, the unused opcode, device zero,
    // wrap, gap, step back, repeat, largest positive gap, then fill and overflow.
    queue_word(OP_REPORT, '0, '0, 1'b0, '0);
    queue_word(OP_TICK, '1, '1, 1'b1, '1);
    queue_word(OP_UNUSED, '1, '1, 1'b1, '1);
    queue_word(OP_MSG, '0, '1, 1'b1, '1);
    queue_word(OP_MSG, pool_dev[0], '1, 1'b0, '0);
    queue_word(OP_MSG, pool_dev[0], '0, 1'b1, '1);
    queue_word(OP_MSG, pool_dev[0], 64'd5, 1'b0, '0);
    queue_word(OP_MSG, pool_dev[0], 64'd3, 1'b0, '1);
    queue_word(OP_MSG, pool_dev[0], 64'd3, 1'b1, 16'h5A5A);
    queue_word(OP_MSG, pool_dev[0], 64'h8000_0000_0000_0003, 1'b0, '0);
    pool_seq[0] = 64'h8000_0000_0000_0003;
    for (int i = 1; i <= TABLE_DEPTH; i++)
      queue_word(OP_MSG, pool_dev[i], pool_seq[i], i[0], (i % 3 == 0) ? '0 : '1);
    queue_word(OP_REPORT, '0, '0, 1'b0, '0);
    wait_drained();

    // Random phases, each under its own credit setting
    for (int ph = 0; ph < 5; ph++) begin
      write_credit(credit_plan[ph]);
      steady_flow = (ph % 2 == 1);
      queue_random(15);
      wait_drained();
    end
    steady_flow = 1'b0;

    // Let any stray word show up before the final verdict.
    repeat (END_PAUSE) @(posedge clk_i);
    if (tracker_out_q.size() != 0) begin
      $error("%0d results never arrived", tracker_out_q.size());
      fail_count++;
    end
    $display("covered %0d words over %0d credit settings: %0d results checked", words_in,
             settings_run + 1, results_in);
    $display("of which %0d stale, %0d report entries, %0d table-full", stale_seen,
             report_seen, full_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
